// ----- rtl/ysmp_pkg.sv -----
// ysmp_pkg: shared types, state encodings and constants of the yuyv bilinear sampler
// no dependencies; imported by every rtl file of the block
package ysmp_pkg;

    typedef struct packed {
        logic [9:0]  frame_width;
        logic [9:0]  frame_height;
        logic [11:0] row_stride;
        logic        format_yuyv;
    } cfg_t;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;
    localparam logic [1:0] REG_FORMAT_YUYV  = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CHECK,
        F_ROW0,
        F_ROW1,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_FETCH,
        B_WAIT,
        B_TOPBOT,
        B_VERT,
        B_CONV1,
        B_CONV2,
        B_CONV3,
        B_CONV4,
        B_OUT
    } back_state_t;

    // bt.601 coefficients in q12
    localparam logic signed [22:0] COEF_RV = 23'sd5743;
    localparam logic signed [22:0] COEF_GU = 23'sd1410;
    localparam logic signed [22:0] COEF_GV = 23'sd2925;
    localparam logic signed [22:0] COEF_BU = 23'sd7258;
    localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;
    localparam logic signed [22:0] CLAMP_MAX = 23'sd1044480;
    localparam logic [22:0] AVG_BIAS = 23'd12288;
    localparam logic [19:0] DIV3_MUL = 20'd683;
    localparam logic [8:0]  PIXEL_MAX = 9'd255;

endpackage

// ----- rtl/yuyv_bilinear_sampler.sv -----
// a write passes the front's check and push states and the queue to the store once the
// back part is idle; a sample takes the front's row states and the back fetch, blend and
// rgb steps, which a failed check skips; the single byte-wide store port (12 reads) and
// shared blend and rgb steps bound samples, and the back part takes no item while one
// runs; reset clears control state and the registers to 0; the frame store keeps no reset
// and needs no clearing pass; results cannot be stalled and show for one cycle on done
module yuyv_bilinear_sampler
    import ysmp_pkg::*;
#(
    parameter int FRAME_BYTES = 262144,
    parameter int FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [17:0] byte_address,
    input  logic [7:0]  byte_value,
    input  logic [17:0] row_pos,
    input  logic [17:0] col_pos,
    output logic        done,
    output logic        ok,
    output logic [7:0]  luma,
    output logic [7:0]  chroma_u,
    output logic [7:0]  chroma_v,
    output logic [7:0]  rgb_average
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int DW = 1 + 1 + 18 + 8 + 2 * AW + 20 + 2 * FRAC_BITS;

    cfg_t cfg_reg;

    logic                 push_valid, push_ready;
    logic                 q_op, q_fail;
    logic [17:0]          q_waddr;
    logic [7:0]           q_wdata;
    logic [AW-1:0]        q_base0, q_base1;
    logic [9:0]           q_col0, q_col1;
    logic [FRAC_BITS-1:0] q_rfrac, q_cfrac;
    logic [DW-1:0]        push_data, head_data;
    logic                 q_valid, q_pop;

    logic                 h_op, h_fail;
    logic [17:0]          h_waddr;
    logic [7:0]           h_wdata;
    logic [AW-1:0]        h_base0, h_base1;
    logic [9:0]           h_col0, h_col1;
    logic [FRAC_BITS-1:0] h_rfrac, h_cfrac;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  cfg_reg.frame_width <= pwdata[9:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[9:0];
                REG_ROW_STRIDE:   cfg_reg.row_stride <= pwdata[11:0];
                default:          cfg_reg.format_yuyv <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            REG_ROW_STRIDE:   prdata = 32'(cfg_reg.row_stride);
            default:          prdata = 32'(cfg_reg.format_yuyv);
        endcase
    end

    ysmp_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .FRAC_BITS   (FRAC_BITS),
        .AW          (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .row_pos      (row_pos),
        .col_pos      (col_pos),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .q_op         (q_op),
        .q_fail       (q_fail),
        .q_waddr      (q_waddr),
        .q_wdata      (q_wdata),
        .q_base0      (q_base0),
        .q_base1      (q_base1),
        .q_col0       (q_col0),
        .q_col1       (q_col1),
        .q_rfrac      (q_rfrac),
        .q_cfrac      (q_cfrac)
    );

    assign push_data = {q_op, q_fail, q_waddr, q_wdata, q_base0, q_base1,
                        q_col0, q_col1, q_rfrac, q_cfrac};

    ysmp_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .not_full  (push_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_data (head_data)
    );

    assign {h_op, h_fail, h_waddr, h_wdata, h_base0, h_base1,
            h_col0, h_col1, h_rfrac, h_cfrac} = head_data;

    ysmp_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .FRAC_BITS   (FRAC_BITS),
        .AW          (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .h_op        (h_op),
        .h_fail      (h_fail),
        .h_waddr     (h_waddr),
        .h_wdata     (h_wdata),
        .h_base0     (h_base0),
        .h_base1     (h_base1),
        .h_col0      (h_col0),
        .h_col1      (h_col1),
        .h_rfrac     (h_rfrac),
        .h_cfrac     (h_cfrac),
        .done        (done),
        .ok          (ok),
        .luma        (luma),
        .chroma_u    (chroma_u),
        .chroma_v    (chroma_v),
        .rgb_average (rgb_average)
    );

endmodule

// ----- rtl/ysmp_front.sv -----
// ysmp_front: accepts items, runs the frame and bounds checks and computes row base addresses
// depends on ysmp_pkg; feeds ysmp_queue
module ysmp_front
    import ysmp_pkg::*;
#(
    parameter int FRAME_BYTES = 262144,
    parameter int FRAC_BITS = 8,
    parameter int AW = $clog2(FRAME_BYTES)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 start,
    output logic                 busy,
    input  logic                 op,
    input  logic [17:0]          byte_address,
    input  logic [7:0]           byte_value,
    input  logic [17:0]          row_pos,
    input  logic [17:0]          col_pos,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic                 q_op,
    output logic                 q_fail,
    output logic [17:0]          q_waddr,
    output logic [7:0]           q_wdata,
    output logic [AW-1:0]        q_base0,
    output logic [AW-1:0]        q_base1,
    output logic [9:0]           q_col0,
    output logic [9:0]           q_col1,
    output logic [FRAC_BITS-1:0] q_rfrac,
    output logic [FRAC_BITS-1:0] q_cfrac
);

    localparam int CW = (10 + FRAC_BITS > 18) ? 10 + FRAC_BITS : 18;
    localparam logic [22:0] FB_LIM = 23'(FRAME_BYTES);

    front_state_t state_reg, state_next;

    logic          op_reg;
    logic [17:0]   addr_reg;
    logic [7:0]    data_reg;
    logic [17:0]   rpos_reg;
    logic [17:0]   cpos_reg;
    logic          fail_reg;
    logic [AW-1:0] base0_reg;
    logic [AW-1:0] base1_reg;

    logic [9:0]  row_last, col_last;
    logic [17:0] rp_shift, cp_shift;
    logic [9:0]  r0, c0, r1, c1;
    logic [9:0]  mul_a;
    logic [21:0] prod;
    logic        basic_fail, fit_fail, pos_fail, check_fail, waddr_fail;

    assign row_last = cfg.frame_height - 10'd1;
    assign col_last = cfg.frame_width - 10'd1;
    assign rp_shift = rpos_reg >> FRAC_BITS;
    assign cp_shift = cpos_reg >> FRAC_BITS;
    assign r0 = rp_shift[9:0];
    assign c0 = cp_shift[9:0];
    // far neighbour clamps to the last row or column
    assign r1 = (r0 == row_last) ? r0 : r0 + 10'd1;
    assign c1 = (c0 == col_last) ? c0 : c0 + 10'd1;

    assign prod = 22'(mul_a) * 22'(cfg.row_stride);

    assign basic_fail = !cfg.format_yuyv || (cfg.frame_width == 10'd0) ||
                        cfg.frame_width[0] || (cfg.frame_height == 10'd0);
    assign fit_fail = (23'(prod) + 23'({cfg.frame_width, 1'b0})) > FB_LIM;
    assign pos_fail = (CW'(rpos_reg) > (CW'(row_last) << FRAC_BITS)) ||
                      (CW'(cpos_reg) > (CW'(col_last) << FRAC_BITS));
    assign check_fail = basic_fail || fit_fail || pos_fail;
    assign waddr_fail = 23'(addr_reg) >= FB_LIM;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                if (op_reg == OP_WRITE || check_fail)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    state_next = F_ROW0;
                end
            end
            F_ROW0:  state_next = F_ROW1;
            F_ROW1:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != F_IDLE);
        push_valid = (state_reg == F_PUSH);
        case (state_reg)
            F_ROW0:  mul_a = r0;
            F_ROW1:  mul_a = r1;
            default: mul_a = row_last;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    op_reg <= op;
                    addr_reg <= byte_address;
                    data_reg <= byte_value;
                    rpos_reg <= row_pos;
                    cpos_reg <= col_pos;
                end
            end
            F_CHECK:
            begin
                fail_reg <= (op_reg == OP_WRITE) ? waddr_fail : check_fail;
            end
            F_ROW0:  base0_reg <= AW'(prod);
            F_ROW1:  base1_reg <= AW'(prod);
            default:
            begin
            end
        endcase
    end

    assign q_op = op_reg;
    assign q_fail = fail_reg;
    assign q_waddr = addr_reg;
    assign q_wdata = data_reg;
    assign q_base0 = base0_reg;
    assign q_base1 = base1_reg;
    assign q_col0 = c0;
    assign q_col1 = c1;
    assign q_rfrac = rpos_reg[FRAC_BITS-1:0];
    assign q_cfrac = cpos_reg[FRAC_BITS-1:0];

endmodule

// ----- rtl/ysmp_queue.sv -----
// ysmp_queue: two-entry fifo between the front and the back part
// depends on ysmp_pkg only by convention; generic data width
module ysmp_queue
    import ysmp_pkg::*;
#(
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          not_full,
    input  logic          pop,
    output logic          not_empty,
    output logic [DW-1:0] head_data
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push, do_pop;

    assign not_full = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push = push && not_full;
    assign do_pop = pop && not_empty;
    assign head_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/ysmp_back.sv -----
// ysmp_back: frame store, twelve-byte neighbour fetch, bilinear blend and rgb conversion
// depends on ysmp_pkg; fed by ysmp_queue
module ysmp_back
    import ysmp_pkg::*;
#(
    parameter int FRAME_BYTES = 262144,
    parameter int FRAC_BITS = 8,
    parameter int AW = $clog2(FRAME_BYTES)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic                 h_op,
    input  logic                 h_fail,
    input  logic [17:0]          h_waddr,
    input  logic [7:0]           h_wdata,
    input  logic [AW-1:0]        h_base0,
    input  logic [AW-1:0]        h_base1,
    input  logic [9:0]           h_col0,
    input  logic [9:0]           h_col1,
    input  logic [FRAC_BITS-1:0] h_rfrac,
    input  logic [FRAC_BITS-1:0] h_cfrac,
    output logic                 done,
    output logic                 ok,
    output logic [7:0]           luma,
    output logic [7:0]           chroma_u,
    output logic [7:0]           chroma_v,
    output logic [7:0]           rgb_average
);

    localparam int TW = 8 + FRAC_BITS;
    localparam int SW = 8 + 2 * FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SW-1:0] HALF = SW'(1) << (2 * FRAC_BITS - 1);

    back_state_t state_reg, state_next;

    logic [7:0]    store_mem [FRAME_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we, issue;

    logic [AW-1:0]        base0_reg, base1_reg;
    logic [9:0]           col0_reg, col1_reg;
    logic [FRAC_BITS-1:0] rf_reg, cf_reg;
    logic [1:0]           pix_reg, comp_reg, chan_reg;
    logic [1:0]           cap_pix_reg, cap_comp_reg;
    logic                 cap_en_reg;
    logic [7:0]           pix_byte [4][3];

    logic [TW-1:0] top_reg, bot_reg;
    logic [SW-1:0] vsum;
    logic          ok_reg;
    logic [7:0]    luma_reg, cu_reg, cv_reg, avg_reg;

    logic signed [22:0] prv_reg, pgu_reg, pgv_reg, pbu_reg, y_reg;
    logic [21:0]        sum_reg;
    logic [9:0]         q_reg;
    logic signed [8:0]  u_s, v_s;
    logic signed [22:0] r_raw, g_raw, b_raw;
    logic [19:0]        r_cl, g_cl, b_cl;
    logic [22:0]        avg_num;
    logic [19:0]        avg_prod;
    logic [FRAC_BITS:0] icf, irf;
    logic [AW-1:0]      row_base;
    logic [9:0]         col_sel;
    logic [AW-1:0]      col_off;
    logic               fetch_last;

    function automatic logic [19:0] clamp_q12(input logic signed [22:0] x);
        logic [19:0] res;
        if (x < 0)
        begin
            res = 20'd0;
        end
        else if (x > CLAMP_MAX)
        begin
            res = CLAMP_MAX[19:0];
        end
        else
        begin
            res = x[19:0];
        end
        return res;
    endfunction

    // address of one of the twelve bytes: pixel pair base plus luma or chroma offset
    assign row_base = pix_reg[1] ? base1_reg : base0_reg;
    assign col_sel = pix_reg[0] ? col1_reg : col0_reg;
    always_comb
    begin
        case (comp_reg)
            2'd0:    col_off = AW'({col_sel[9:1], 2'b00}) + AW'({col_sel[0], 1'b0});
            2'd1:    col_off = AW'({col_sel[9:1], 2'b00}) + AW'(1);
            default: col_off = AW'({col_sel[9:1], 2'b00}) + AW'(3);
        endcase
    end
    assign rd_addr = row_base + col_off;
    assign fetch_last = (pix_reg == 2'd3) && (comp_reg == 2'd2);

    assign icf = ONE - {1'b0, cf_reg};
    assign irf = ONE - {1'b0, rf_reg};
    assign vsum = SW'(top_reg) * SW'(irf) + SW'(bot_reg) * SW'(rf_reg) + HALF;

    assign u_s = $signed({1'b0, cu_reg}) - CHROMA_OFFSET;
    assign v_s = $signed({1'b0, cv_reg}) - CHROMA_OFFSET;
    assign r_raw = y_reg + prv_reg;
    assign g_raw = y_reg - pgu_reg - pgv_reg;
    assign b_raw = y_reg + pbu_reg;
    assign r_cl = clamp_q12(r_raw);
    assign g_cl = clamp_q12(g_raw);
    assign b_cl = clamp_q12(b_raw);
    assign avg_num = 23'({sum_reg, 1'b0}) + AVG_BIAS;
    // divide by three with a reciprocal, exact for the value range here
    assign avg_prod = 20'(q_reg) * DIV3_MUL;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && h_op == OP_SAMPLE)
                begin
                    state_next = h_fail ? B_OUT : B_FETCH;
                end
            end
            B_FETCH:
            begin
                if (fetch_last)
                begin
                    state_next = B_WAIT;
                end
            end
            B_WAIT:   state_next = B_TOPBOT;
            B_TOPBOT: state_next = B_VERT;
            B_VERT:   state_next = (chan_reg == 2'd2) ? B_CONV1 : B_TOPBOT;
            B_CONV1:  state_next = B_CONV2;
            B_CONV2:  state_next = B_CONV3;
            B_CONV3:  state_next = B_CONV4;
            B_CONV4:  state_next = B_OUT;
            B_OUT:    state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == B_IDLE) && q_valid;
        mem_we = (state_reg == B_IDLE) && q_valid && (h_op == OP_WRITE) && !h_fail;
        issue = (state_reg == B_FETCH);
        done = (state_reg == B_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cap_en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_en_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[AW'(h_waddr)] <= h_wdata;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cap_pix_reg <= pix_reg;
        cap_comp_reg <= comp_reg;
        if (cap_en_reg)
        begin
            pix_byte[cap_pix_reg][cap_comp_reg] <= rd_data_reg;
        end
        case (state_reg)
            B_IDLE:
            begin
                base0_reg <= h_base0;
                base1_reg <= h_base1;
                col0_reg <= h_col0;
                col1_reg <= h_col1;
                rf_reg <= h_rfrac;
                cf_reg <= h_cfrac;
                pix_reg <= 2'd0;
                comp_reg <= 2'd0;
                chan_reg <= 2'd0;
                ok_reg <= !h_fail;
                luma_reg <= 8'd0;
                cu_reg <= 8'd0;
                cv_reg <= 8'd0;
                avg_reg <= 8'd0;
            end
            B_FETCH:
            begin
                if (comp_reg == 2'd2)
                begin
                    comp_reg <= 2'd0;
                    pix_reg <= pix_reg + 2'd1;
                end
                else
                begin
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            B_TOPBOT:
            begin
                top_reg <= TW'(pix_byte[0][0]) * TW'(icf) + TW'(pix_byte[1][0]) * TW'(cf_reg);
                bot_reg <= TW'(pix_byte[2][0]) * TW'(icf) + TW'(pix_byte[3][0]) * TW'(cf_reg);
            end
            B_VERT:
            begin
                case (chan_reg)
                    2'd0:    luma_reg <= vsum[2*FRAC_BITS+7:2*FRAC_BITS];
                    2'd1:    cu_reg <= vsum[2*FRAC_BITS+7:2*FRAC_BITS];
                    default: cv_reg <= vsum[2*FRAC_BITS+7:2*FRAC_BITS];
                endcase
                chan_reg <= chan_reg + 2'd1;
                // next channel moves into the first component slot
                for (int p = 0; p < 4; p++)
                begin
                    pix_byte[p][0] <= pix_byte[p][1];
                    pix_byte[p][1] <= pix_byte[p][2];
                end
            end
            B_CONV1:
            begin
                y_reg <= 23'({luma_reg, 12'd0});
                prv_reg <= 23'(v_s) * COEF_RV;
                pgu_reg <= 23'(u_s) * COEF_GU;
                pgv_reg <= 23'(v_s) * COEF_GV;
                pbu_reg <= 23'(u_s) * COEF_BU;
            end
            B_CONV2:
            begin
                sum_reg <= 22'(r_cl) + 22'(g_cl) + 22'(b_cl);
            end
            B_CONV3:
            begin
                q_reg <= avg_num[22:13];
            end
            B_CONV4:
            begin
                avg_reg <= (avg_prod[19:11] > PIXEL_MAX) ? 8'd255 : avg_prod[18:11];
            end
            default:
            begin
            end
        endcase
    end

    assign ok = ok_reg;
    assign luma = luma_reg;
    assign chroma_u = cu_reg;
    assign chroma_v = cv_reg;
    assign rgb_average = avg_reg;

endmodule

// ----- rtl/ysmp_checker.sv -----
// ysmp_checker: port-level assertions for the yuyv bilinear sampler
// depends on the top level's ports; attached by the bind below
module ysmp_checker
    import ysmp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       ok,
    input logic [7:0] luma,
    input logic [7:0] chroma_u,
    input logic [7:0] chroma_v,
    input logic [7:0] rgb_average
);

    // results are spaced apart by the back part's sequencing
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("front not busy after accepting an item");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (luma == 8'd0 && chroma_u == 8'd0 &&
                           chroma_v == 8'd0 && rgb_average == 8'd0))
        else $error("failed sample with nonzero outputs");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind yuyv_bilinear_sampler ysmp_checker u_ysmp_checker (.*);
